// ===== design/bsf_pkg.sv =====
// Shared constants and types for the bit-stuffing framer with CRC-16.
// Used by bsf_crc, bsf_ctrl and bit_stuff_framer_crc16; no dependencies.
`timescale 1ns / 1ps

package bsf_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic        APPEND_CRC_RESET = 1'b1;

  // One line bit with its markers
  typedef struct packed {
    logic last_of_run;
    logic frame_end;
    logic line_bit;
  } bsf_res_t;

  // Commands from the sequencer to the CRC unit
  typedef struct packed {
    logic clear;
    logic upd;
    logic data_bit;
    logic shift;
  } bsf_crc_ctl_t;

endpackage

// ===== design/bit_stuff_framer_crc16.sv =====
// Channel   Dir  Signals                          Contents
// s_axis    in   tvalid tready tdata[7:0] tlast   data_byte, last_byte
// m_axis    out  tvalid tready tdata[7:0] tuser   line_bit; frame_end; tlast = last_of_run
//                tlast
// cfg       in   cfg_valid cfg_ready cfg_data     append_crc
//
// One line bit leaves per cycle while m_axis drains; the sequencer steps
// only when the output register is free. Each accepted byte goes out as
// 8 to 10 line bits; a frame end adds 16 to 20 CRC bits (when enabled),
// 8 flag bits and up to 7 pad bits, and an opening flag adds 8 bits.
// s_axis is ready only while the sequencer is idle. Synchronous reset
// returns the block to idle outside a frame with append_crc set.
`timescale 1ns / 1ps

module bit_stuff_framer_crc16 (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] line_bit, [7:1] zero
  output logic       m_axis_tuser,   // [0] frame_end
  output logic       m_axis_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import bsf_pkg::*;

  logic         append_crc;
  logic         step;
  logic         emit;
  logic         crc_msb;
  bsf_crc_ctl_t crc_ctl;
  bsf_res_t     res;
  bsf_res_t     out_q;

  assign cfg_ready = 1'b1;

  // Hold the CRC append option
  always_ff @(posedge clk) begin
    if (rst) begin
      append_crc <= APPEND_CRC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      append_crc <= cfg_data;
    end
  end

  // Advance the sequencer whenever the output register can take a bit
  assign step = !m_axis_tvalid || m_axis_tready;

  bsf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .append_crc (append_crc),
    .step       (step),
    .crc_msb    (crc_msb),
    .crc_ctl    (crc_ctl),
    .emit       (emit),
    .res        (res)
  );

  bsf_crc u_crc (
    .clk     (clk),
    .rst     (rst),
    .ctl     (crc_ctl),
    .crc_msb (crc_msb)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= emit;
    end
    if (step && emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tdata = {7'b0, out_q.line_bit};
  assign m_axis_tuser = out_q.frame_end;
  assign m_axis_tlast = out_q.last_of_run;

`ifndef SYNTHESIS
  a_frame_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame end without end of run");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transaction");

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");
`endif

endmodule

// ===== design/bsf_crc.sv =====
// Bit-serial CRC-16 unit (poly 0x1021, init 0): updates one data bit per cycle
// while upd is set, and shifts the result out MSB first. Depends on bsf_pkg.
`timescale 1ns / 1ps

module bsf_crc (
  input  logic                  clk,
  input  logic                  rst,
  input  bsf_pkg::bsf_crc_ctl_t ctl,
  output logic                  crc_msb
);
  import bsf_pkg::*;

  logic [15:0] crc;
  logic        fb;

  assign fb      = crc[15] ^ ctl.data_bit;
  assign crc_msb = crc[15];

  // Clear, fold in a data bit, or shift out the remainder
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      crc <= '0;
    end else if (ctl.upd) begin
      crc <= {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end else if (ctl.shift) begin
      crc <= {crc[14:0], 1'b0};
    end
  end

endmodule

// ===== design/bsf_ctrl.sv =====
// Framing sequencer: opening flag, stuffed data and CRC bits, closing flag
// and pad, one line bit per step. Depends on bsf_pkg and drives bsf_crc.
`timescale 1ns / 1ps

module bsf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  input  logic                  append_crc,
  input  logic                  step,
  input  logic                  crc_msb,
  output bsf_pkg::bsf_crc_ctl_t crc_ctl,
  output logic                  emit,
  output bsf_pkg::bsf_res_t     res
);
  import bsf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_OPEN, ST_DATA, ST_CRC, ST_CLOSE, ST_PAD
  } state_t;

  state_t      st, st_next;
  logic [4:0]  cnt, cnt_next, cnt_inc;
  logic [7:0]  shreg, shreg_next;
  logic        last_q, last_next;
  logic        app_q, app_next;
  logic        in_frame, in_frame_next;
  logic [2:0]  ones, ones_next;
  logic [2:0]  phase, phase_next;
  logic        pend, pend_next;
  logic        bit_out;
  logic        end_frame;

  assign in_ready = (st == ST_IDLE);

  // Next-state and line-bit selection
  always_comb begin
    st_next       = st;
    cnt_next      = cnt;
    cnt_inc       = cnt;
    shreg_next    = shreg;
    last_next     = last_q;
    app_next      = app_q;
    in_frame_next = in_frame;
    ones_next     = ones;
    phase_next    = phase;
    pend_next     = pend;
    bit_out       = 1'b0;
    end_frame     = 1'b0;
    emit          = 1'b0;
    res           = '0;
    crc_ctl       = '0;

    case (st)
      ST_IDLE: begin
        if (in_valid) begin
          shreg_next    = in_byte;
          last_next     = in_last;
          app_next      = append_crc;
          cnt_next      = '0;
          in_frame_next = 1'b1;
          st_next       = in_frame ? ST_DATA : ST_OPEN;
        end
      end
      ST_OPEN: begin
        if (step) begin
          emit     = 1'b1;
          bit_out  = FLAG_BYTE[~cnt[2:0]];
          cnt_next = cnt + 5'd1;
          if (cnt[2:0] == 3'd7) begin
            cnt_next = '0;
            st_next  = ST_DATA;
          end
        end
      end
      ST_DATA, ST_CRC: begin
        if (step) begin
          emit       = 1'b1;
          phase_next = phase + 3'd1;
          if (pend) begin
            // Insert the stuffed zero after five ones
            bit_out   = 1'b0;
            pend_next = 1'b0;
            ones_next = '0;
          end else begin
            cnt_inc = cnt + 5'd1;
            if (st == ST_DATA) begin
              bit_out          = shreg[7];
              shreg_next       = {shreg[6:0], 1'b0};
              crc_ctl.upd      = 1'b1;
              crc_ctl.data_bit = shreg[7];
            end else begin
              bit_out       = crc_msb;
              crc_ctl.shift = 1'b1;
            end
            if (bit_out) begin
              if (ones == 3'd4) begin
                ones_next = '0;
                pend_next = 1'b1;
              end else begin
                ones_next = ones + 3'd1;
              end
            end else begin
              ones_next = '0;
            end
          end
          cnt_next = cnt_inc;
          if (!pend_next && (cnt_inc == ((st == ST_DATA) ? 5'd8 : 5'd16))) begin
            cnt_next = '0;
            if (st == ST_CRC) begin
              st_next = ST_CLOSE;
            end else if (!last_q) begin
              st_next         = ST_IDLE;
              res.last_of_run = 1'b1;
            end else begin
              st_next = app_q ? ST_CRC : ST_CLOSE;
            end
          end
        end
      end
      ST_CLOSE: begin
        if (step) begin
          emit       = 1'b1;
          bit_out    = FLAG_BYTE[~cnt[2:0]];
          phase_next = phase + 3'd1;
          cnt_next   = cnt + 5'd1;
          if (cnt[2:0] == 3'd7) begin
            cnt_next = '0;
            if (phase_next == 3'd0) begin
              end_frame = 1'b1;
            end else begin
              st_next = ST_PAD;
            end
          end
        end
      end
      ST_PAD: begin
        if (step) begin
          emit       = 1'b1;
          bit_out    = 1'b0;
          phase_next = phase + 3'd1;
          if (phase_next == 3'd0) begin
            end_frame = 1'b1;
          end
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase

    // Close the frame and return to idle
    if (end_frame) begin
      res.frame_end   = 1'b1;
      res.last_of_run = 1'b1;
      st_next         = ST_IDLE;
      in_frame_next   = 1'b0;
      ones_next       = '0;
      phase_next      = '0;
      pend_next       = 1'b0;
      crc_ctl.clear   = 1'b1;
    end

    res.line_bit = bit_out;
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      cnt      <= '0;
      in_frame <= 1'b0;
      ones     <= '0;
      phase    <= '0;
      pend     <= 1'b0;
      last_q   <= 1'b0;
      app_q    <= 1'b0;
    end else begin
      st       <= st_next;
      cnt      <= cnt_next;
      in_frame <= in_frame_next;
      ones     <= ones_next;
      phase    <= phase_next;
      pend     <= pend_next;
      last_q   <= last_next;
      app_q    <= app_next;
    end
    shreg <= shreg_next;
  end

endmodule
